### rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV/RGB converter package
// Direction codes, sector codes and shared widths for the converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int SECT_W = 3;

  localparam logic FUNC_HSV2RGB = 1'b0;
  localparam logic FUNC_RGB2HSV = 1'b1;

  localparam logic [SECT_W-1:0] SECT_0 = 3'd0;
  localparam logic [SECT_W-1:0] SECT_1 = 3'd1;
  localparam logic [SECT_W-1:0] SECT_2 = 3'd2;
  localparam logic [SECT_W-1:0] SECT_3 = 3'd3;
  localparam logic [SECT_W-1:0] SECT_4 = 3'd4;

endpackage

### rtl/hsvrgb_if.sv
// ----------------------------------------------------------------------------
// HSV/RGB converter channels
// Valid/ready channels for the pixel words going in and coming out.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if #(parameter int W = 13);
  logic         valid;
  logic         ready;
  logic         func;
  logic [W-1:0] comp_a;
  logic [W-1:0] comp_b;
  logic [W-1:0] comp_c;
  modport source (output valid, func, comp_a, comp_b, comp_c, input ready);
  modport sink   (input valid, func, comp_a, comp_b, comp_c, output ready);
endinterface

interface hsvrgb_out_if #(parameter int W = 13);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_a;
  logic [W-1:0] out_b;
  logic [W-1:0] out_c;
  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink   (input valid, out_a, out_b, out_c, output ready);
endinterface

### rtl/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// HSV/RGB converter front end
// Saturates the input word and classifies it: sector and fraction of the hue,
// or maximum, delta and hue numerator of the color.
// ----------------------------------------------------------------------------
module hsvrgb_front #(
  parameter int F = 12
) (
  hsvrgb_in_if.sink         in_ch,
  input  logic              q_full,
  output logic              q_wr,
  output logic [7*F+15:0]   q_wdata
);
  import hsvrgb_pkg::*;

  localparam int W  = F + 1;
  localparam int NW = F + 3;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic              func;
    logic              szero;
    logic [SECT_W-1:0] sector;
    logic [F-1:0]      frac;
    logic [W-1:0]      s;
    logic [W-1:0]      v;
    logic              dz;
    logic [W-1:0]      mx;
    logic [W-1:0]      delta;
    logic [NW-1:0]     n;
    logic [NW-1:0]     d6;
  } rec_t;

  logic [W-1:0]  a, b, c, h, mx, mn, delta;
  logic [NW-1:0] h6, d6, n;
  rec_t          rec;

  always_comb begin
    a = (in_ch.comp_a > ONE) ? ONE : in_ch.comp_a;
    b = (in_ch.comp_b > ONE) ? ONE : in_ch.comp_b;
    c = (in_ch.comp_c > ONE) ? ONE : in_ch.comp_c;
    h = (a == ONE) ? '0 : a;
    h6 = NW'(h) * NW'(6);
    mx = a;
    mn = a;
    if (b > mx) mx = b;
    if (c > mx) mx = c;
    if (b < mn) mn = b;
    if (c < mn) mn = c;
    delta = mx - mn;
    d6 = NW'(delta) * NW'(6);
    if (mx == a) begin
      n = (b >= c) ? NW'(b - c) : (d6 - NW'(c - b));
    end else if (mx == b) begin
      n = (NW'(delta) << 1) + NW'(c) - NW'(a);
    end else begin
      n = (NW'(delta) << 2) + NW'(a) - NW'(b);
    end
    rec.func   = in_ch.func;
    rec.szero  = (b == '0);
    rec.sector = h6[F +: SECT_W];
    rec.frac   = h6[F-1:0];
    rec.s      = b;
    rec.v      = c;
    rec.dz     = (delta == '0);
    rec.mx     = mx;
    rec.delta  = delta;
    rec.n      = n;
    rec.d6     = d6;
  end

  assign in_ch.ready = !q_full;
  assign q_wr        = in_ch.valid && !q_full;
  assign q_wdata     = rec;

endmodule

### rtl/hsvrgb_fifo.sv
// ----------------------------------------------------------------------------
// HSV/RGB converter queue
// Two-entry queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module hsvrgb_fifo #(
  parameter int RW = 100
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  logic [RW-1:0] wdata,
  output logic          full,
  input  logic          rd,
  output logic          rvalid,
  output logic [RW-1:0] rdata
);
  import hsvrgb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [RW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  assign full   = (cnt_r == (PW+1)'(DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

endmodule

### rtl/hsvrgb_back.sv
// ----------------------------------------------------------------------------
// HSV/RGB converter back end
// Pipeline of F stages: the HSV products in the first two stages, and two
// restoring dividers, one quotient bit per stage, for saturation and hue.
// ----------------------------------------------------------------------------
module hsvrgb_back #(
  parameter int F = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  logic [7*F+15:0] q_rdata,
  output logic            q_rd,
  hsvrgb_out_if.source    out_ch
);
  import hsvrgb_pkg::*;

  localparam int W  = F + 1;
  localparam int NW = F + 3;
  localparam int L  = F;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic              func;
    logic              szero;
    logic [SECT_W-1:0] sector;
    logic [F-1:0]      frac;
    logic [W-1:0]      s;
    logic [W-1:0]      v;
    logic              dz;
    logic [W-1:0]      mx;
    logic [W-1:0]      delta;
    logic [NW-1:0]     n;
    logic [NW-1:0]     d6;
  } rec_t;

  typedef struct packed {
    logic              func;
    logic              szero;
    logic [SECT_W-1:0] sector;
    logic              dz;
    logic              sfull;
    logic [W-1:0]      v;
    logic [W-1:0]      mx;
    logic [W-1:0]      s;
    logic [W-1:0]      sf;
    logic [W-1:0]      sf1;
    logic [W-1:0]      p;
    logic [W-1:0]      q;
    logic [W-1:0]      t;
    logic [W-1:0]      rs;
    logic [W-1:0]      ds;
    logic [F-1:0]      qs;
    logic [NW-1:0]     rh;
    logic [NW-1:0]     dh;
    logic [F-1:0]      qh;
  } stage_t;

  function automatic logic [W-1:0] mul_fx(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [2*W-1:0] prod;
    prod = (2*W)'(x) * (2*W)'(y);
    return prod[F +: W];
  endfunction

  function automatic stage_t div_step(input stage_t st);
    stage_t       r;
    logic [W:0]   rs2;
    logic [NW:0]  rh2;
    r   = st;
    rs2 = {st.rs, 1'b0};
    rh2 = {st.rh, 1'b0};
    if (rs2 >= {1'b0, st.ds}) begin
      r.rs = W'(rs2 - {1'b0, st.ds});
      r.qs = {st.qs[F-2:0], 1'b1};
    end else begin
      r.rs = W'(rs2);
      r.qs = {st.qs[F-2:0], 1'b0};
    end
    if (rh2 >= {1'b0, st.dh}) begin
      r.rh = NW'(rh2 - {1'b0, st.dh});
      r.qh = {st.qh[F-2:0], 1'b1};
    end else begin
      r.rh = NW'(rh2);
      r.qh = {st.qh[F-2:0], 1'b0};
    end
    return r;
  endfunction

  rec_t         rec;
  stage_t       pre;
  stage_t       stg_r   [L];
  stage_t       stg_nxt [L];
  logic [L-1:0] vld_r;
  logic         en;
  stage_t       last;

  assign rec = q_rdata;

  always_comb begin
    pre        = '0;
    pre.func   = rec.func;
    pre.szero  = rec.szero;
    pre.sector = rec.sector;
    pre.dz     = rec.dz;
    pre.sfull  = (rec.delta == rec.mx);
    pre.v      = rec.v;
    pre.mx     = rec.mx;
    pre.s      = rec.s;
    pre.sf     = mul_fx(rec.s, W'(rec.frac));
    pre.sf1    = mul_fx(rec.s, ONE - W'(rec.frac));
    pre.rs     = rec.delta;
    pre.ds     = rec.mx;
    pre.rh     = rec.n;
    pre.dh     = rec.d6;
    stg_nxt[0] = div_step(pre);
    for (int k = 1; k < L; k++) begin
      stg_nxt[k] = div_step(stg_r[k-1]);
    end
    stg_nxt[1].p = mul_fx(stg_r[0].v, ONE - stg_r[0].s);
    stg_nxt[1].q = mul_fx(stg_r[0].v, ONE - stg_r[0].sf);
    stg_nxt[1].t = mul_fx(stg_r[0].v, ONE - stg_r[0].sf1);
  end

  assign en   = !vld_r[L-1] || out_ch.ready;
  assign q_rd = en && q_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], q_valid};
    end
  end

  assign last         = stg_r[L-1];
  assign out_ch.valid = vld_r[L-1];

  always_comb begin
    out_ch.out_a = last.v;
    out_ch.out_b = last.v;
    out_ch.out_c = last.v;
    if (last.func == FUNC_RGB2HSV) begin
      out_ch.out_c = last.mx;
      if (last.dz) begin
        out_ch.out_a = '0;
        out_ch.out_b = '0;
      end else begin
        out_ch.out_a = W'(last.qh);
        out_ch.out_b = last.sfull ? ONE : W'(last.qs);
      end
    end else if (!last.szero) begin
      case (last.sector)
        SECT_0: begin
          out_ch.out_a = last.v; out_ch.out_b = last.t; out_ch.out_c = last.p;
        end
        SECT_1: begin
          out_ch.out_a = last.q; out_ch.out_b = last.v; out_ch.out_c = last.p;
        end
        SECT_2: begin
          out_ch.out_a = last.p; out_ch.out_b = last.v; out_ch.out_c = last.t;
        end
        SECT_3: begin
          out_ch.out_a = last.p; out_ch.out_b = last.q; out_ch.out_c = last.v;
        end
        SECT_4: begin
          out_ch.out_a = last.t; out_ch.out_b = last.p; out_ch.out_c = last.v;
        end
        default: begin
          out_ch.out_a = last.v; out_ch.out_b = last.p; out_ch.out_c = last.q;
        end
      endcase
    end
  end

endmodule

### rtl/hsv_rgb_color_converter_top.sv
// ----------------------------------------------------------------------------
// HSV/RGB color converter, top level
// Converts one pixel word per clock, HSV/RGB by func, while out_ch is ready.
// ----------------------------------------------------------------------------
// The block takes one word per clock and gives one result word per clock when
// the output side is ready. A word passes the front end into a two-entry
// queue and then a FRAC_BITS-stage back end, whose stages are set by the two
// restoring dividers that produce one quotient bit per stage. When the output
// stalls, the back end holds and the queue fills with up to two words before
// in_ch.ready falls; in_ch.ready rises again in the cycle after the output
// side resumes.
module hsv_rgb_color_converter_top #(
  parameter int FRAC_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  hsvrgb_in_if.sink     in_ch,
  hsvrgb_out_if.source  out_ch
);
  import hsvrgb_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int RW = 7 * FRAC_BITS + 16;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic          q_full, q_wr, q_rd, q_valid;
  logic [RW-1:0] q_wdata, q_rdata;

  hsvrgb_front #(.F(FRAC_BITS)) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  hsvrgb_fifo #(.RW(RW)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .full   (q_full),
    .rd     (q_rd),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  hsvrgb_back #(.F(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_rd    (q_rd),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_a <= ONE && out_ch.out_b <= ONE && out_ch.out_c <= ONE))
    else $error("Result word component above one.");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> q_valid)
    else $error("Back end read from an empty queue.");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("Result word valid right after reset.");
`endif

endmodule
